// ----- design/rfp_pkg.sv -----
// Shared types, constants and CRC helper for the range frame parser.
`default_nettype none
package rfp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h54;

	localparam int FILL_W = 5;
	localparam logic [FILL_W-1:0] STORE_DEPTH  = 5'd19;
	localparam logic [FILL_W-1:0] CRC_LAST_IDX = 5'd17;
	localparam logic [FILL_W-1:0] FIRST_DATA   = 5'd1;

	localparam int PAYLOAD_BYTES = 16;
	localparam int PAYLOAD_OFS   = 2;
	localparam int MAX_SENSORS   = 8;
	localparam int SENSOR_W      = 3;
	localparam int RANGE_W       = 15;
	localparam int SEQ_W         = 32;
	localparam int POLY_W        = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM   = 2'd2;

	localparam logic [POLY_W-1:0]  POLY_RESET = 8'h07;
	localparam logic [RANGE_W-1:0] MIN_RESET  = 15'd200;
	localparam logic [RANGE_W-1:0] MAX_RESET  = 15'd14000;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [PAYLOAD_BYTES-1:0][7:0] frame_t;

	typedef enum logic [1:0] {
		FRONT_FILL,
		FRONT_CHECK,
		FRONT_PUSH
	} front_state_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
		input logic [POLY_W-1:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- design/rfp_front.sv -----
// Front end: byte intake, frame store and CRC check of a completed frame.
`default_nettype none
module rfp_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [rfp_pkg::POLY_W-1:0] crc_poly,
	input  wire logic                       rx_valid,
	output logic                            rx_ready,
	input  wire logic [7:0]                 rx_byte,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output rfp_pkg::frame_t                 push_frame
);
	import rfp_pkg::*;

	front_state_t      state_q, state_d;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        store_q [1:STORE_DEPTH-1];
	logic [7:0]        crc_q;
	logic [7:0]        crc_d;
	logic [FILL_W-1:0] idx_q;
	logic              accept;
	logic              is_sync;
	logic              full;
	logic              store_word;
	logic              start_check;

	assign accept      = rx_valid && rx_ready;
	assign is_sync     = rx_byte == SYNC_BYTE;
	assign full        = fill_q == STORE_DEPTH;
	assign store_word  = accept && !is_sync && !full;
	assign start_check = accept && is_sync && full;
	assign crc_d       = crc8_byte(crc_q, store_q[idx_q], crc_poly);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rx_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			FRONT_FILL: begin
				rx_ready = 1'b1;
				if (start_check) begin
					state_d = FRONT_CHECK;
				end
			end
			FRONT_CHECK: begin
				if (idx_q == CRC_LAST_IDX) begin
					state_d = (crc_d == store_q[STORE_DEPTH-1]) ? FRONT_PUSH : FRONT_FILL;
				end
			end
			FRONT_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = FRONT_FILL;
				end
			end
			default: begin
				state_d = FRONT_FILL;
			end
		endcase
	end

	// restart on sync, overflow or a byte that completes nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FIRST_DATA;
		end else if (store_word) begin
			fill_q <= fill_q + FIRST_DATA;
		end else if (accept) begin
			fill_q <= FIRST_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (store_word) begin
			store_q[fill_q] <= rx_byte;
		end
		if (start_check) begin
			crc_q <= crc8_byte(8'h00, SYNC_BYTE, crc_poly);
			idx_q <= FIRST_DATA;
		end else if (state_q == FRONT_CHECK) begin
			crc_q <= crc_d;
			idx_q <= idx_q + FIRST_DATA;
		end
	end

	for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_payload
		assign push_frame[k] = store_q[k+PAYLOAD_OFS];
	end

endmodule
`default_nettype wire

// ----- design/rfp_queue.sv -----
// Short frame queue between the front end and the result generator.
`default_nettype none
module rfp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire rfp_pkg::frame_t push_frame,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output rfp_pkg::frame_t      pop_frame
);
	import rfp_pkg::*;

	frame_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_frame  = entries_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_q] <= push_frame;
		end
	end

endmodule
`default_nettype wire

// ----- design/rfp_back.sv -----
// Back end: per-sensor range extraction, clamping and sequence numbering.
`default_nettype none
module rfp_back #(
	parameter int NUM_SENSORS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pop_valid,
	output logic                             pop_ready,
	input  wire rfp_pkg::frame_t             pop_frame,
	input  wire logic [rfp_pkg::RANGE_W-1:0] min_range_mm,
	input  wire logic [rfp_pkg::RANGE_W-1:0] max_range_mm,
	output logic                             range_valid,
	input  wire logic                        range_ready,
	output logic [rfp_pkg::SENSOR_W-1:0]     sensor_index,
	output logic [rfp_pkg::RANGE_W-1:0]      range_mm,
	output logic [rfp_pkg::SEQ_W-1:0]        seq_number,
	output logic                             last
);
	import rfp_pkg::*;

	localparam logic [SENSOR_W-1:0] LAST_IDX = SENSOR_W'(NUM_SENSORS - 1);

	logic [SENSOR_W-1:0] idx_q;
	logic [SEQ_W-1:0]    seq_q;
	logic                out_valid_q;
	logic [SENSOR_W-1:0] index_q;
	logic [RANGE_W-1:0]  range_q;
	logic [SEQ_W-1:0]    seq_out_q;
	logic                last_q;
	logic                load;
	logic                at_last;
	logic signed [15:0]  value;
	logic signed [15:0]  min_s;
	logic signed [15:0]  max_s;
	logic [RANGE_W-1:0]  clamped;

	assign at_last   = idx_q == LAST_IDX;
	assign load      = pop_valid && (!out_valid_q || range_ready);
	assign pop_ready = load && at_last;

	assign value = $signed({pop_frame[{idx_q, 1'b0}], pop_frame[{idx_q, 1'b1}]});
	assign min_s = $signed({1'b0, min_range_mm});
	assign max_s = $signed({1'b0, max_range_mm});

	always_comb begin
		if (value < min_s) begin
			clamped = min_range_mm;
		end else if (value > max_s) begin
			clamped = max_range_mm;
		end else begin
			clamped = value[RANGE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? '0 : idx_q + SENSOR_W'(1);
				seq_q       <= seq_q + SEQ_W'(1);
				out_valid_q <= 1'b1;
			end else if (range_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			index_q   <= idx_q;
			range_q   <= clamped;
			seq_out_q <= seq_q;
			last_q    <= at_last;
		end
	end

	assign range_valid  = out_valid_q;
	assign sensor_index = index_q;
	assign range_mm     = range_q;
	assign seq_number   = seq_out_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ----- design/range_frame_parser_crc8.sv -----
// Top level of the CRC-8 checked serial range frame parser.
// Takes one received byte per word on the rx channel and assembles frames that open
// with the sync byte 0x54. Ordinary bytes are taken one per cycle. A sync byte that
// closes a full 19-byte frame starts the CRC-8 check: byte 0 is folded in at the accepting
// edge, then bytes 1..17 one per cycle through the front end's CRC unit. rx_ready stays
// low after that sync byte until the check ends, and a passing frame also holds it low
// until it is pushed, longer if the frame queue is full. A passing frame goes to a
// two-frame queue, and the back end emits NUM_SENSORS clamped ranges from it on the range
// channel, one per cycle while range_ready is high. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once; indexes beyond the register list are ignored.
`default_nettype none
module range_frame_parser_crc8 #(
	parameter int NUM_SENSORS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rfp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           rx_valid,
	output logic                                rx_ready,
	input  wire logic [7:0]                     rx_byte,
	output logic                                range_valid,
	input  wire logic                           range_ready,
	output logic [rfp_pkg::SENSOR_W-1:0]        sensor_index,
	output logic [rfp_pkg::RANGE_W-1:0]         range_mm,
	output logic [rfp_pkg::SEQ_W-1:0]           seq_number,
	output logic                                last
);
	import rfp_pkg::*;

	logic [POLY_W-1:0]  crc_poly_q;
	logic [RANGE_W-1:0] min_range_q;
	logic [RANGE_W-1:0] max_range_q;
	logic               push_valid;
	logic               push_ready;
	frame_t             push_frame;
	logic               pop_valid;
	logic               pop_ready;
	frame_t             pop_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q  <= POLY_RESET;
			min_range_q <= MIN_RESET;
			max_range_q <= MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CRC_POLY: crc_poly_q  <= cfg_data[POLY_W-1:0];
				CFG_MIN_MM:   min_range_q <= cfg_data[RANGE_W-1:0];
				CFG_MAX_MM:   max_range_q <= cfg_data[RANGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.crc_poly   (crc_poly_q),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame)
	);

	rfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_frame  (pop_frame)
	);

	rfp_back #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_frame    (pop_frame),
		.min_range_mm (min_range_q),
		.max_range_mm (max_range_q),
		.range_valid  (range_valid),
		.range_ready  (range_ready),
		.sensor_index (sensor_index),
		.range_mm     (range_mm),
		.seq_number   (seq_number),
		.last         (last)
	);

`ifndef SYNTHESIS
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		range_valid |-> (last == (sensor_index == SENSOR_W'(NUM_SENSORS - 1))))
		else $error("last flag does not match final sensor index");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		range_valid && range_ready |=> !range_valid || seq_number == $past(seq_number) + 1)
		else $error("sequence number skipped or repeated");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		range_valid && range_ready && last |=> !range_valid || sensor_index == '0)
		else $error("new frame does not start at sensor zero");
`endif

endmodule
`default_nettype wire
